>>> sv/ascii_radix_converter_unit_defines.svh
// Assertion macros shared by the ascii radix converter RTL.
// Defining NO_ASSERTIONS removes every check; nothing else is required.
`ifndef ASCII_RADIX_CONVERTER_UNIT_DEFINES_SVH
`define ASCII_RADIX_CONVERTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ARC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("arc: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("arc: assertion failed");
`else
`define ARC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/arc_pkg.sv
// Package for the ascii radix converter: radix codes, sequencer states,
// the start control struct and the character helpers. No dependencies.
package arc_pkg;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef enum logic [1:0] {
        RADIX_BIN,
        RADIX_DEC,
        RADIX_HEX
    } t_radix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXTRACT,
        S_FETCH,
        S_LOAD,
        S_SEND
    } t_conv_state;

    // Handoff of a finished number from the accumulator to the converter.
    typedef struct packed {
        logic   valid;
        logic   err;
        t_radix radix;
    } t_start_ctl;

    // Base code three is treated as hexadecimal.
    function automatic t_radix radix_of(logic [1:0] code);
        t_radix r;
        unique case (code)
            2'd0:    r = RADIX_BIN;
            2'd1:    r = RADIX_DEC;
            default: r = RADIX_HEX;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] char_of(logic [3:0] d);
        logic [7:0] c;
        if (d > 4'd9) begin
            c = 8'(d) - 8'd10 + CH_LOWER_A;
        end else begin
            c = 8'(d) + CH_ZERO;
        end
        return c;
    endfunction

endpackage

>>> sv/arc_in_if.sv
// Input channel of the ascii radix converter: one character per item.
// No dependencies.
interface arc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic [1:0] source_base;
    logic [1:0] target_base;
    logic       final_digit;

    modport source (output valid, digit_char, source_base, target_base, final_digit,
                    input ready);
    modport sink   (input valid, digit_char, source_base, target_base, final_digit,
                    output ready);
endinterface

>>> sv/arc_out_if.sv
// Output channel of the ascii radix converter: one emitted character per item.
// No dependencies.
interface arc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic       bad_digit;

    modport source (output valid, out_char, out_last, bad_digit, input ready);
    modport sink   (input valid, out_char, out_last, bad_digit, output ready);
endinterface

>>> sv/ascii_radix_converter_unit.sv
// Usage: characters of one number enter on i_in, one item per character, most
// significant digit first, with source and target base codes (0 binary,
// 1 decimal, 2 or 3 hexadecimal) and final_digit on the last character.
// Valid digits build the value modulo 2^VALUE_BITS; any other byte is skipped
// and sets bad_digit on every character of that number's output run.
// After the final character the value leaves on o_out as ASCII digits in the
// target base, most significant first, with out_last on the final one; zero
// gives the single character "0".
// Flow: i_in takes characters while no finished number is pending. After a final
// character i_in is held off until the converter takes the value, which it does
// once idle; characters of the next number are taken during the conversion, but
// after its final character i_in waits until the converter returns to idle.
// Conversion: binary and hexadecimal take each target digit by a plain shift;
// decimal uses a bit-serial restoring divider. Each output character then
// passes through a memory read, an output load and a handshake.
// A stalled receiver simply holds the current character; the sequencer waits.
// Reset is synchronous and active low: the accumulated value, error and pending
// flags, sequencer state and digit counters are cleared and any run in progress
// is dropped; the other data registers keep their contents. The digit memory is
// not cleared and needs no pass.
module ascii_radix_converter_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arc_in_if.sink     i_in,
    arc_out_if.source  o_out
);

    // Handoff from the accumulator to the converter: control as a struct,
    // the finished value alongside at the parameterised width.
    arc_pkg::t_start_ctl   start;
    logic [VALUE_BITS-1:0] start_value;
    logic                  start_ready;

    // The accumulator decodes each character and folds it into the value.
    arc_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_start       (start),
        .o_start_value (start_value),
        .i_start_ready (start_ready)
    );

    // The converter peels off target digits into its memory, then replays
    // them in reverse order onto the output channel.
    arc_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_start_value (start_value),
        .o_start_ready (start_ready),
        .o_out         (o_out)
    );

endmodule

>>> sv/arc_accum.sv
// Character decoder and value accumulator of the ascii radix converter.
// Depends on arc_pkg, arc_in_if and the assertion macro header.
`include "ascii_radix_converter_unit_defines.svh"

module arc_accum #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    arc_in_if.sink                  i_in,
    output arc_pkg::t_start_ctl     o_start,
    output logic [VALUE_BITS-1:0]   o_start_value,
    input  logic                    i_start_ready
);

    logic [VALUE_BITS-1:0] r_value;
    logic                  r_err;
    logic                  r_pend;
    arc_pkg::t_radix       r_tradix;

    logic                  is_num;
    logic                  is_alpha;
    logic [3:0]            dig;
    logic                  dig_ok;
    arc_pkg::t_radix       src_radix;
    logic [VALUE_BITS-1:0] n_value;
    logic                  in_fire;
    logic                  start_fire;

    always_comb begin
        is_num    = (i_in.digit_char >= arc_pkg::CH_ZERO) &&
                    (i_in.digit_char <= arc_pkg::CH_NINE);
        is_alpha  = (i_in.digit_char >= arc_pkg::CH_LOWER_A) &&
                    (i_in.digit_char <= arc_pkg::CH_LOWER_F);
        dig       = is_num ? 4'(i_in.digit_char - arc_pkg::CH_ZERO)
                           : 4'(i_in.digit_char - arc_pkg::CH_LOWER_A + 8'd10);
        src_radix = arc_pkg::radix_of(i_in.source_base);
        unique case (src_radix)
            arc_pkg::RADIX_BIN: begin
                dig_ok  = is_num && (dig < 4'd2);
                n_value = {r_value[VALUE_BITS-2:0], dig[0]};
            end
            arc_pkg::RADIX_DEC: begin
                dig_ok  = is_num;
                // value * 10 as value * 8 + value * 2, wrapping at the register width
                n_value = (r_value << 3) + (r_value << 1) +
                          {{(VALUE_BITS-4){1'b0}}, dig};
            end
            default: begin
                dig_ok  = is_num || is_alpha;
                n_value = {r_value[VALUE_BITS-5:0], dig};
            end
        endcase
    end

    assign i_in.ready    = !r_pend;
    assign in_fire       = i_in.valid && !r_pend;
    assign start_fire    = r_pend && i_start_ready;

    assign o_start.valid = r_pend;
    assign o_start.err   = r_err;
    assign o_start.radix = r_tradix;
    assign o_start_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_err   <= 1'b0;
            r_pend  <= 1'b0;
        end else if (start_fire) begin
            r_value <= '0;
            r_err   <= 1'b0;
            r_pend  <= 1'b0;
        end else if (in_fire) begin
            if (dig_ok) begin
                r_value <= n_value;
            end else begin
                r_err <= 1'b1;
            end
            if (i_in.final_digit) begin
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.final_digit) begin
            r_tradix <= arc_pkg::radix_of(i_in.target_base);
        end
    end

    `ARC_ASSERT_NEXT(a_final_pends, i_clk, i_rst_n, in_fire && i_in.final_digit, r_pend)

endmodule

>>> sv/arc_conv.sv
// Digit-serial radix converter and output sequencer with its digit memory.
// Depends on arc_pkg, arc_out_if and the assertion macro header.
`include "ascii_radix_converter_unit_defines.svh"

module arc_conv #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  arc_pkg::t_start_ctl     i_start,
    input  logic [VALUE_BITS-1:0]   i_start_value,
    output logic                    o_start_ready,
    arc_out_if.source               o_out
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    arc_pkg::t_conv_state  r_state;
    arc_pkg::t_conv_state  n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_step;
    logic [IDX_W-1:0]      r_rd;
    logic [VALUE_BITS-1:0] r_val;
    logic [3:0]            r_rem;
    logic                  r_err;
    arc_pkg::t_radix       r_radix;
    logic [3:0]            r_q;
    logic [7:0]            r_char;
    logic                  r_last;
    logic [3:0]            r_mem [VALUE_BITS];

    logic [4:0]            rem5;
    logic                  rem_ge;
    logic [3:0]            n_rem;
    logic [VALUE_BITS-1:0] ext_val;
    logic [3:0]            ext_digit;
    logic                  digit_rdy;
    logic                  quot_zero;
    logic                  wr_en;
    logic                  start_fire;
    logic                  out_fire;

    // One restoring division step per cycle for decimal, a plain shift otherwise.
    always_comb begin
        rem5   = {r_rem, r_val[VALUE_BITS-1]};
        rem_ge = rem5 >= 5'd10;
        n_rem  = rem_ge ? 4'(rem5 - 5'd10) : rem5[3:0];
        unique case (r_radix)
            arc_pkg::RADIX_BIN: begin
                ext_val   = r_val >> 1;
                ext_digit = {3'b000, r_val[0]};
                digit_rdy = 1'b1;
            end
            arc_pkg::RADIX_DEC: begin
                ext_val   = {r_val[VALUE_BITS-2:0], rem_ge};
                ext_digit = n_rem;
                digit_rdy = r_step == IDX_W'(VALUE_BITS - 1);
            end
            default: begin
                ext_val   = r_val >> 4;
                ext_digit = r_val[3:0];
                digit_rdy = 1'b1;
            end
        endcase
        quot_zero = ext_val == '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arc_pkg::S_IDLE:    if (i_start.valid) n_state = arc_pkg::S_EXTRACT;
            arc_pkg::S_EXTRACT: if (digit_rdy && quot_zero) n_state = arc_pkg::S_FETCH;
            arc_pkg::S_FETCH:   n_state = arc_pkg::S_LOAD;
            arc_pkg::S_LOAD:    n_state = arc_pkg::S_SEND;
            arc_pkg::S_SEND: begin
                if (o_out.ready) begin
                    n_state = r_last ? arc_pkg::S_IDLE : arc_pkg::S_FETCH;
                end
            end
            default:            n_state = arc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_start_ready   = r_state == arc_pkg::S_IDLE;
        wr_en           = (r_state == arc_pkg::S_EXTRACT) && digit_rdy;
        o_out.valid     = r_state == arc_pkg::S_SEND;
        o_out.out_char  = r_char;
        o_out.out_last  = r_last;
        o_out.bad_digit = r_err;
    end

    assign start_fire = o_start_ready && i_start.valid;
    assign out_fire   = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arc_pkg::S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (start_fire) begin
                r_cnt  <= '0;
                r_step <= '0;
            end else if (r_state == arc_pkg::S_EXTRACT) begin
                if (digit_rdy) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_fire) begin
            r_val   <= i_start_value;
            r_rem   <= '0;
            r_err   <= i_start.err;
            r_radix <= i_start.radix;
        end else if (r_state == arc_pkg::S_EXTRACT) begin
            r_val <= ext_val;
            r_rem <= digit_rdy ? 4'd0 : n_rem;
            if (digit_rdy) begin
                r_rd <= r_cnt[IDX_W-1:0];
            end
        end
        if (r_state == arc_pkg::S_LOAD) begin
            r_char <= arc_pkg::char_of(r_q);
            r_last <= r_rd == '0;
        end
        if ((r_state == arc_pkg::S_SEND) && o_out.ready && !r_last) begin
            r_rd <= r_rd - 1'b1;
        end
    end

    // Digit memory, least significant digit at the lowest address.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[IDX_W-1:0]] <= ext_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[r_rd];
    end

    `ARC_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(VALUE_BITS))
    `ARC_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, out_fire && o_out.out_last, r_state == arc_pkg::S_IDLE)
    `ARC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, start_fire, (r_cnt == '0) && (r_state == arc_pkg::S_EXTRACT))

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII radix converter: random and directed
// numbers, a scoreboard that predicts every output character. Uses arc_pkg and both channel interfaces.

// Predicts the character runs of the converter and checks them as they leave.
class radix_scoreboard #(int VBITS = 32);
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } t_out_char;

    logic [VBITS-1:0] acc_value;
    logic             err_seen;
    t_out_char        run_q[$];
    int unsigned      error_count;
    int unsigned      chars_checked;
    int unsigned      numbers_done;

    function new();
        acc_value     = '0;
        err_seen      = 1'b0;
        error_count   = 0;
        chars_checked = 0;
        numbers_done  = 0;
    endfunction

    // Codes other than binary and decimal select hexadecimal.
    function int unsigned base_of(logic [1:0] code);
        int unsigned b;
        case (code)
            arc_pkg::RADIX_BIN: b = 2;
            arc_pkg::RADIX_DEC: b = 10;
            default:            b = 16;
        endcase
        return b;
    endfunction

    function int digit_value(logic [7:0] ch, int unsigned base);
        int d;
        d = -1;
        if (ch >= arc_pkg::CH_ZERO && ch <= arc_pkg::CH_NINE) begin
            d = int'(ch - arc_pkg::CH_ZERO);
        end else if (ch >= arc_pkg::CH_LOWER_A && ch <= arc_pkg::CH_LOWER_F) begin
            d = int'(ch - arc_pkg::CH_LOWER_A) + 10;
        end
        if (d >= int'(base)) begin
            d = -1;
        end
        return d;
    endfunction

    function logic [7:0] ascii_of(logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = arc_pkg::CH_ZERO + 8'(d);
        end else begin
            c = arc_pkg::CH_LOWER_A + 8'(d) - 8'd10;
        end
        return c;
    endfunction

    // Called for every accepted input item.
    function void note_input(logic [7:0] ch, logic [1:0] src, logic [1:0] dst, logic fin);
        int               d;
        int unsigned      sbase;
        int unsigned      tbase;
        logic [VBITS-1:0] v;
        logic [3:0]       digits[$];
        t_out_char        item;
        sbase = base_of(src);
        tbase = base_of(dst);
        d     = digit_value(ch, sbase);
        if (d < 0) begin
            err_seen = 1'b1;
        end else begin
            acc_value = acc_value * VBITS'(sbase) + VBITS'(d);
        end
        if (!fin) begin
            return;
        end
        // Digits come out least significant first; zero still yields one digit.
        v = acc_value;
        do begin
            digits.push_front(4'(v % VBITS'(tbase)));
            v = v / VBITS'(tbase);
        end while (v != 0);
        foreach (digits[k]) begin
            item.ch   = ascii_of(digits[k]);
            item.last = (k == digits.size() - 1);
            item.bad  = err_seen;
            run_q.push_back(item);
        end
        acc_value = '0;
        err_seen  = 1'b0;
        numbers_done++;
    endfunction

    // Called for every accepted output item.
    function void check_char(logic [7:0] ch, logic last, logic bad);
        t_out_char exp;
        chars_checked++;
        if (run_q.size() == 0) begin
            $error("unexpected output character %h (last %b, bad %b)", ch, last, bad);
            error_count++;
            return;
        end
        exp = run_q.pop_front();
        if (ch !== exp.ch) begin
            $error("out_char: expected %h, got %h", exp.ch, ch);
            error_count++;
        end
        if (last !== exp.last) begin
            $error("out_last: expected %b, got %b", exp.last, last);
            error_count++;
        end
        if (bad !== exp.bad) begin
            $error("bad_digit: expected %b, got %b", exp.bad, bad);
            error_count++;
        end
    endfunction

    function int pending();
        return run_q.size();
    endfunction
endclass

module testbench;
    localparam int VALUE_BITS   = 32;
    localparam int PHASE_ITEMS  = 65;
    localparam int MAX_GAP      = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 60;

    localparam logic [1:0] CODE_BIN     = arc_pkg::RADIX_BIN;
    localparam logic [1:0] CODE_DEC     = arc_pkg::RADIX_DEC;
    localparam logic [1:0] CODE_HEX     = arc_pkg::RADIX_HEX;
    localparam logic [1:0] CODE_HEX_ALT = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic hold_request;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   items_sent;

    radix_scoreboard #(VALUE_BITS) sb;

    arc_in_if  in_ch ();
    arc_out_if out_ch ();

    ascii_radix_converter_unit #(.VALUE_BITS(VALUE_BITS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one item, after a random idle gap, and waits for it to be taken.
    task automatic send_char(logic [7:0] ch, logic [1:0] src, logic [1:0] dst, logic fin);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.digit_char  <= ch;
        in_ch.source_base <= src;
        in_ch.target_base <= dst;
        in_ch.final_digit <= fin;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        sb.note_input(ch, src, dst, fin);
        items_sent++;
    endtask

    task automatic send_text(string s, logic [1:0] src, logic [1:0] dst);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], src, dst, i == s.len() - 1);
        end
    endtask

    // Mostly well-formed numbers, short as a rule, now and then long or made
    // of the largest digit so that the value wraps; a few stray bytes.
    task automatic send_random_number();
        logic [1:0]  src;
        logic [1:0]  dst;
        int unsigned base;
        int unsigned len;
        int unsigned dval;
        bit          all_max;
        logic [7:0]  ch;
        src  = 2'($urandom_range(3));
        dst  = 2'($urandom_range(3));
        base = sb.base_of(src);
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(36, 5);
        end else begin
            len = $urandom_range(4, 1);
        end
        all_max = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8) begin
                ch = 8'($urandom());
            end else begin
                dval = all_max ? base - 1 : $urandom_range(base - 1);
                ch   = sb.ascii_of(4'(dval));
            end
            send_char(ch, src, dst, i == len - 1);
        end
    endtask

    // Stops offering and waits until every predicted character has left.
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    // Receiver: checks each accepted item and chooses ready for the next cycle.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_char(out_ch.out_char, out_ch.out_last, out_ch.bad_digit);
            end
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        i_rst_n           <= 1'b0;
        hold_request      <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.digit_char  <= 8'h00;
        in_ch.source_base <= CODE_BIN;
        in_ch.target_base <= CODE_BIN;
        in_ch.final_digit <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed numbers: zero, wrap to the largest value as a full binary
        // run, invalid characters of several kinds, and both hexadecimal codes.
        send_text("0", CODE_BIN, CODE_BIN);
        send_text("1ffffffff", CODE_HEX, CODE_BIN);
        send_text("z", CODE_DEC, CODE_DEC);
        send_text("12", CODE_BIN, CODE_HEX);
        send_text("a9", CODE_DEC, CODE_HEX_ALT);
        send_text("fF", CODE_HEX_ALT, CODE_DEC);
        send_char(8'h00, CODE_HEX, CODE_DEC, 1'b0);
        send_char(8'hff, CODE_HEX, CODE_DEC, 1'b1);
        send_text("99", CODE_DEC, CODE_HEX);
        drain_outputs();

        for (int p = 0; p < 4; p++) begin
            int phase_start;
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                    // A long hold-off at the receiver lets the block back up.
                    hold_request <= 1'b1;
                end
                default: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_number();
            end
            drain_outputs();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected characters never arrived", sb.pending());
            sb.error_count++;
        end
        $display("Run covered %0d input characters forming %0d numbers, %0d output characters",
                 items_sent, sb.numbers_done, sb.chars_checked);
        $display("checked, over four phases of sender idling and receiver stalling.");
        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/arc_pkg.sv
sv/arc_in_if.sv
sv/arc_out_if.sv
sv/arc_accum.sv
sv/arc_conv.sv
sv/ascii_radix_converter_unit.sv
test/testbench.sv
